FILE: rtl/core/rfsl_pkg.sv
`default_nettype none

package rfsl_pkg;

    localparam int LOG_DEPTH = 1024;
    localparam int MIN_FRAME = 9;

    localparam int ADDR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [15:0] SEQ_CRC_MARK = 16'hffff;
    localparam logic [31:0] CNT_MAX      = 32'hffff_ffff;

    typedef enum logic [1:0] {
        MODE_GOOD  = 2'd0,
        MODE_CRC   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } rfsl_mode_t;

    // One log entry as stored in the RAM.
    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  rssi;
        logic [7:0]  lqi;
        logic [31:0] t_start;
        logic [31:0] t_stop;
    } rfsl_entry_t;

    localparam int ENTRY_W = $bits(rfsl_entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/rfsl_ram.sv
`default_nettype none

module rfsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/rx_frame_stats_logger.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// command   | mode, frame_length, tx_id, seq_id, ...  | beat taken when start & !busy
// result    | logged_count ... entry_end              | one-cycle beat marked by done
//
// One beat is taken every cycle; busy never rises. A result passes through
// the input register, where the counters update and the log RAM is written
// or read, and then through the output registers.
// Reset clears the counters and owner id; the log RAM is not cleared, since
// only entries below the fill count are ever read back.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module rx_frame_stats_logger
    import rfsl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          mode,
    input  wire logic [7:0]          frame_length,
    input  wire logic [31:0]         tx_id,
    input  wire logic [15:0]         seq_id,
    input  wire logic [7:0]          size_byte,
    input  wire logic [7:0]          rssi,
    input  wire logic [7:0]          lqi,
    input  wire logic [31:0]         start_time,
    input  wire logic [31:0]         end_time,
    input  wire logic [ADDR_W-1:0]   read_index,
    output logic                     done,
    output logic [CNT_W-1:0]         logged_count,
    output logic [31:0]              error_count,
    output logic [31:0]              change_count,
    output logic [31:0]              current_tx,
    output logic                     entry_valid,
    output logic [15:0]              entry_seq,
    output logic [7:0]               entry_rssi,
    output logic [7:0]               entry_lqi,
    output logic [31:0]              entry_start,
    output logic [31:0]              entry_end
);

    // ---------------------------------------------------------------
    // Input register: hold the accepted command beat.
    // ---------------------------------------------------------------
    logic                in_valid_reg;
    rfsl_mode_t          in_mode_reg;
    logic [7:0]          in_len_reg;
    logic [31:0]         in_tx_reg;
    logic [15:0]         in_seq_reg;
    logic [7:0]          in_size_reg;
    logic [7:0]          in_rssi_reg;
    logic [7:0]          in_lqi_reg;
    logic [31:0]         in_t0_reg;
    logic [31:0]         in_t1_reg;
    logic [ADDR_W-1:0]   in_idx_reg;

    logic                accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_mode_reg <= rfsl_mode_t'(mode);
            in_len_reg  <= frame_length;
            in_tx_reg   <= tx_id;
            in_seq_reg  <= seq_id;
            in_size_reg <= size_byte;
            in_rssi_reg <= rssi;
            in_lqi_reg  <= lqi;
            in_t0_reg   <= start_time;
            in_t1_reg   <= end_time;
            in_idx_reg  <= read_index;
        end
    end

    // ---------------------------------------------------------------
    // Logger state. These registers also drive the counter outputs:
    // during the result cycle they hold the values after that beat.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [31:0]         errors_reg, errors_next;
    logic [31:0]         changes_reg, changes_next;
    logic [31:0]         owner_tx_reg, owner_tx_next;
    logic [7:0]          owner_size_reg, owner_size_next;
    logic                done_reg;
    logic                rd_valid_reg, rd_valid_next;

    // RAM port signals
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    rfsl_entry_t         wr_entry;
    rfsl_entry_t         rd_entry;

    always_comb
    begin
        logic              frame_bad;
        logic              do_log;
        logic              log_full;
        logic [1:0]        err_inc;
        logic [CNT_W-1:0]  base_count;
        logic [33:0]       err_sum;

        count_next      = count_reg;
        errors_next     = errors_reg;
        changes_next    = changes_reg;
        owner_tx_next   = owner_tx_reg;
        owner_size_next = owner_size_reg;
        rd_valid_next   = 1'b0;

        frame_bad  = (in_len_reg < 8'(MIN_FRAME)) || (in_size_reg != in_len_reg);
        do_log     = 1'b0;
        err_inc    = 2'd0;
        base_count = count_reg;

        wr_entry.seq     = in_seq_reg;
        wr_entry.rssi    = in_rssi_reg;
        wr_entry.lqi     = in_lqi_reg;
        wr_entry.t_start = in_t0_reg;
        wr_entry.t_stop  = in_t1_reg;

        case (in_mode_reg)
            MODE_GOOD:
            begin
                if (frame_bad)
                begin
                    err_inc = 2'd1;
                end
                else
                begin
                    // A new transmitter restarts the log and relearns id and size.
                    if (count_reg != '0)
                    begin
                        if (owner_tx_reg != in_tx_reg)
                        begin
                            changes_next    = (changes_reg == CNT_MAX) ? changes_reg
                                                                      : changes_reg + 32'd1;
                            base_count      = '0;
                            owner_tx_next   = in_tx_reg;
                            owner_size_next = in_size_reg;
                        end
                    end
                    else
                    begin
                        owner_tx_next   = in_tx_reg;
                        owner_size_next = in_size_reg;
                    end
                    // Same-id size mismatch: count it but still log the frame.
                    if (owner_size_next != in_size_reg)
                    begin
                        err_inc = 2'd1;
                    end
                    do_log = 1'b1;
                end
            end
            MODE_CRC:
            begin
                wr_entry.seq  = SEQ_CRC_MARK;
                wr_entry.rssi = '0;
                wr_entry.lqi  = '0;
                do_log        = 1'b1;
            end
            MODE_CLEAR:
            begin
                base_count   = '0;
                errors_next  = '0;
                changes_next = '0;
            end
            MODE_READ:
            begin
                rd_valid_next = ({1'b0, in_idx_reg} < count_reg);
            end
            default:
            begin
                base_count = count_reg;
            end
        endcase

        // Drop the entry and count an error when the log is full.
        log_full = (base_count >= CNT_W'(LOG_DEPTH));
        if (do_log && log_full)
        begin
            err_inc = err_inc + 2'd1;
        end

        wr_en   = in_valid_reg && do_log && !log_full;
        wr_addr = base_count[ADDR_W-1:0];

        if (in_mode_reg != MODE_CLEAR)
        begin
            count_next = wr_en ? base_count + CNT_W'(1) : base_count;
            err_sum    = {2'b00, errors_reg} + {32'd0, err_inc};
            errors_next = (err_sum > {2'b00, CNT_MAX}) ? CNT_MAX : err_sum[31:0];
        end
        else
        begin
            count_next = base_count;
            err_sum    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            errors_reg     <= '0;
            changes_reg    <= '0;
            owner_tx_reg   <= '0;
            owner_size_reg <= '0;
            done_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            done_reg     <= in_valid_reg;
            rd_valid_reg <= in_valid_reg & rd_valid_next;
            if (in_valid_reg)
            begin
                count_reg      <= count_next;
                errors_reg     <= errors_next;
                changes_reg    <= changes_next;
                owner_tx_reg   <= owner_tx_next;
                owner_size_reg <= owner_size_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Log RAM: one write port for appends, one registered read port for
    // read-back. A read never targets the slot written in the same cycle.
    // ---------------------------------------------------------------
    rfsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (in_idx_reg),
        .rdata (rd_entry)
    );

    // ---------------------------------------------------------------
    // Result beat: counters from the state registers, entry fields
    // forced to zero unless this beat is a valid read.
    // ---------------------------------------------------------------
    assign done         = done_reg;
    assign logged_count = count_reg;
    assign error_count  = errors_reg;
    assign change_count = changes_reg;
    assign current_tx   = owner_tx_reg;
    assign entry_valid  = rd_valid_reg;
    assign entry_seq    = rd_valid_reg ? rd_entry.seq     : '0;
    assign entry_rssi   = rd_valid_reg ? rd_entry.rssi    : '0;
    assign entry_lqi    = rd_valid_reg ? rd_entry.lqi     : '0;
    assign entry_start  = rd_valid_reg ? rd_entry.t_start : '0;
    assign entry_end    = rd_valid_reg ? rd_entry.t_stop  : '0;

endmodule

`default_nettype wire

FILE: dv/rfsl_checker.sv
`default_nettype none

module rfsl_checker
    import rfsl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        mode,
    input  wire logic [7:0]        frame_length,
    input  wire logic [31:0]       tx_id,
    input  wire logic [15:0]       seq_id,
    input  wire logic [7:0]        size_byte,
    input  wire logic [7:0]        rssi,
    input  wire logic [7:0]        lqi,
    input  wire logic [31:0]       start_time,
    input  wire logic [31:0]       end_time,
    input  wire logic [ADDR_W-1:0] read_index,
    input  wire logic              done,
    input  wire logic [CNT_W-1:0]  logged_count,
    input  wire logic [31:0]       error_count,
    input  wire logic [31:0]       change_count,
    input  wire logic [31:0]       current_tx,
    input  wire logic              entry_valid,
    input  wire logic [15:0]       entry_seq,
    input  wire logic [7:0]        entry_rssi,
    input  wire logic [7:0]        entry_lqi,
    input  wire logic [31:0]       entry_start,
    input  wire logic [31:0]       entry_end,
    output int                     fails,
    output int                     pending,
    output int                     hint_fill,
    output int                     hint_hwm,
    output int                     n_beats,
    output int                     n_hits,
    output int                     n_full,
    output int                     n_changes,
    output int                     n_clears
);

    typedef struct {
        logic [CNT_W-1:0] logged;
        logic [31:0]      errs;
        logic [31:0]      chgs;
        logic [31:0]      owner;
        logic             hit;
        rfsl_entry_t      ent;
    } stats_result_t;

    // Mirror of the logger state.
    int          fill;
    int          hwm;
    logic [31:0] err_cnt;
    logic [31:0] chg_cnt;
    logic [31:0] owner_id;
    logic [7:0]  owner_sz;
    rfsl_entry_t log_mem [LOG_DEPTH];

    stats_result_t stats_q[$];
    stats_result_t got_r;
    int            fail_n, beat_n, hit_n, full_n, chg_n, clr_n;

    assign fails     = fail_n;
    assign n_beats   = beat_n;
    assign n_hits    = hit_n;
    assign n_full    = full_n;
    assign n_changes = chg_n;
    assign n_clears  = clr_n;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic void append_entry(rfsl_entry_t e);
        if (fill >= LOG_DEPTH) begin
            err_cnt = bump(err_cnt);
            full_n++;
            return;
        end
        log_mem[fill] = e;
        fill++;
        if (fill > hwm)
            hwm = fill;
    endfunction

    function automatic stats_result_t step_logger();
        stats_result_t r;
        rfsl_entry_t   e;
        r = '{default: '0};
        e.seq     = seq_id;
        e.rssi    = rssi;
        e.lqi     = lqi;
        e.t_start = start_time;
        e.t_stop  = end_time;
        case (rfsl_mode_t'(mode))
            MODE_GOOD: begin
                if (frame_length < MIN_FRAME || size_byte != frame_length) begin
                    err_cnt = bump(err_cnt);
                end else begin
                    if (fill >= 1) begin
                        if (owner_id != tx_id) begin
                            chg_cnt  = bump(chg_cnt);
                            chg_n++;
                            fill     = 0;
                            owner_id = tx_id;
                            owner_sz = size_byte;
                        end
                    end else begin
                        owner_id = tx_id;
                        owner_sz = size_byte;
                    end
                    if (owner_sz != size_byte)
                        err_cnt = bump(err_cnt);
                    append_entry(e);
                end
            end
            MODE_CRC: begin
                e.seq  = SEQ_CRC_MARK;
                e.rssi = '0;
                e.lqi  = '0;
                append_entry(e);
            end
            MODE_CLEAR: begin
                fill    = 0;
                err_cnt = '0;
                chg_cnt = '0;
                clr_n++;
            end
            default: begin
                if (int'(read_index) < fill) begin
                    r.hit = 1'b1;
                    r.ent = log_mem[read_index];
                    hit_n++;
                end
            end
        endcase
        r.logged = CNT_W'(fill);
        r.errs   = err_cnt;
        r.chgs   = chg_cnt;
        r.owner  = owner_id;
        return r;
    endfunction

    function automatic void check_fld(string nm, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_n++;
            if (fail_n <= 20)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, nm, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill     = 0;
            hwm      = 0;
            err_cnt  = '0;
            chg_cnt  = '0;
            owner_id = '0;
            owner_sz = '0;
            stats_q.delete();
            pending   <= 0;
            hint_fill <= 0;
            hint_hwm  <= 0;
        end else begin
            // Retire first: a beat taken at this edge reports later.
            if (done) begin
                if (stats_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 20)
                        $display("%0t: result beat with nothing expected", $time);
                end else begin
                    got_r = stats_q.pop_front();
                    check_fld("logged_count", 32'(got_r.logged), 32'(logged_count));
                    check_fld("error_count", got_r.errs, error_count);
                    check_fld("change_count", got_r.chgs, change_count);
                    check_fld("current_tx", got_r.owner, current_tx);
                    check_fld("entry_valid", 32'(got_r.hit), 32'(entry_valid));
                    check_fld("entry_seq", 32'(got_r.ent.seq), 32'(entry_seq));
                    check_fld("entry_rssi", 32'(got_r.ent.rssi), 32'(entry_rssi));
                    check_fld("entry_lqi", 32'(got_r.ent.lqi), 32'(entry_lqi));
                    check_fld("entry_start", got_r.ent.t_start, entry_start);
                    check_fld("entry_end", got_r.ent.t_stop, entry_end);
                end
            end
            if (start && !busy) begin
                stats_q.push_back(step_logger());
                beat_n++;
            end
            pending   <= stats_q.size();
            hint_fill <= fill;
            hint_hwm  <= hwm;
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
    import rfsl_pkg::*;

    // Far above the slowest legal run: ~2.2k beats, each with a random idle gap.
    localparam int LIMIT = 200000;

    typedef struct {
        rfsl_mode_t        mode;
        logic [7:0]        frame_length;
        logic [31:0]       tx_id;
        logic [15:0]       seq_id;
        logic [7:0]        size_byte;
        logic [7:0]        rssi;
        logic [7:0]        lqi;
        logic [31:0]       start_time;
        logic [31:0]       end_time;
        logic [ADDR_W-1:0] read_index;
    } frame_beat_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        mode;
    logic [7:0]        frame_length;
    logic [31:0]       tx_id;
    logic [15:0]       seq_id;
    logic [7:0]        size_byte;
    logic [7:0]        rssi;
    logic [7:0]        lqi;
    logic [31:0]       start_time;
    logic [31:0]       end_time;
    logic [ADDR_W-1:0] read_index;
    logic              done;
    logic [CNT_W-1:0]  logged_count;
    logic [31:0]       error_count;
    logic [31:0]       change_count;
    logic [31:0]       current_tx;
    logic              entry_valid;
    logic [15:0]       entry_seq;
    logic [7:0]        entry_rssi;
    logic [7:0]        entry_lqi;
    logic [31:0]       entry_start;
    logic [31:0]       entry_end;

    // Checker feedback: verdict, drain status, and hints for aiming reads.
    int fails, pending, hint_fill, hint_hwm;
    int n_beats, n_hits, n_full, n_changes, n_clears;

    int cycles;
    int sent;
    bit calm;

    rx_frame_stats_logger dut (.*);
    rfsl_checker          chk (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pick a read index that only ever lands on a log slot written at some
    // point. The hints lag one beat, but the high-water mark never shrinks,
    // so a lagged value is still safe. Aim below the fill level for hits.
    function automatic logic [ADDR_W-1:0] pick_index(bit aim_hit);
        if (aim_hit && hint_fill > 0)
            return ADDR_W'($urandom_range(hint_fill - 1));
        if (hint_hwm > 0)
            return ADDR_W'($urandom_range(hint_hwm - 1));
        return '0;
    endfunction

    // Build a beat with random payload; header fields are given.
    function automatic frame_beat_t beat_of(rfsl_mode_t m, logic [31:0] tx,
                                            logic [7:0] len, logic [7:0] sz);
        frame_beat_t b;
        b.mode         = m;
        b.frame_length = len;
        b.tx_id        = tx;
        b.size_byte    = sz;
        b.seq_id       = 16'($urandom);
        b.rssi         = 8'($urandom);
        b.lqi          = 8'($urandom);
        b.start_time   = $urandom;
        b.end_time     = $urandom;
        b.read_index   = pick_index(m == MODE_READ);
        return b;
    endfunction

    // Present one beat, hold it until taken, then idle for a random gap.
    // Keep start high across back-to-back beats: never drop and raise it in
    // the same step.
    task automatic push_beat(input frame_beat_t b);
        int gap;
        start        <= 1'b1;
        mode         <= b.mode;
        frame_length <= b.frame_length;
        tx_id        <= b.tx_id;
        seq_id       <= b.seq_id;
        size_byte    <= b.size_byte;
        rssi         <= b.rssi;
        lqi          <= b.lqi;
        start_time   <= b.start_time;
        end_time     <= b.end_time;
        read_index   <= b.read_index;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        // Toggle between idle-free stretches and gappy ones now and then.
        if ($urandom_range(39) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_read(input logic [ADDR_W-1:0] idx);
        frame_beat_t b;
        b = beat_of(MODE_READ, $urandom, 8'($urandom), 8'($urandom));
        b.read_index = idx;
        push_beat(b);
    endtask

    // Fill one transmitter's log past its depth: mostly well-formed frames,
    // some CRC events, a few same-id size changes and reads along the way.
    task automatic fill_burst();
        frame_beat_t b;
        logic [31:0] tx;
        logic [7:0]  len, odd;
        int          n_log, target, r;
        tx     = $urandom;
        len    = 8'($urandom_range(255, MIN_FRAME));
        target = LOG_DEPTH + $urandom_range(40, 6);
        n_log  = 0;
        while (n_log < target) begin
            r = $urandom_range(99);
            if (r < 12) begin
                b = beat_of(MODE_CRC, $urandom, 8'($urandom), 8'($urandom));
                n_log++;
            end else if (r < 20) begin
                b = beat_of(MODE_READ, $urandom, 8'($urandom), 8'($urandom));
            end else if (r < 24) begin
                odd = 8'($urandom_range(255, MIN_FRAME));
                b   = beat_of(MODE_GOOD, tx, odd, odd);
                n_log++;
            end else begin
                b = beat_of(MODE_GOOD, tx, len, len);
                n_log++;
            end
            push_beat(b);
        end
        // Read back across the whole log once it is full.
        repeat (12) push_read(pick_index(1'b1));
    endtask

    // A short run of traffic around a few transmitters: well-formed frames
    // dominate, with id switches, CRC events, reads, bad headers, clears
    // and fully random noise mixed in.
    task automatic session();
        frame_beat_t b;
        logic [31:0] tx_pool [3];
        logic [31:0] tx;
        logic [7:0]  len, bad;
        int          n, r;
        tx_pool[0] = $urandom;
        tx_pool[1] = $urandom;
        tx_pool[2] = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        tx  = tx_pool[$urandom_range(2)];
        len = 8'($urandom_range(255, MIN_FRAME));
        n   = $urandom_range(40, 4);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 60) begin
                if ($urandom_range(9) == 0)
                    tx = tx_pool[$urandom_range(2)];
                if ($urandom_range(19) == 0)
                    len = 8'($urandom_range(255, MIN_FRAME));
                b = beat_of(MODE_GOOD, tx, len, len);
            end else if (r < 70) begin
                b = beat_of(MODE_CRC, $urandom, 8'($urandom), 8'($urandom));
            end else if (r < 82 && hint_hwm > 0) begin
                b = beat_of(MODE_READ, $urandom, 8'($urandom), 8'($urandom));
                b.read_index = pick_index($urandom_range(3) != 0);
            end else if (r < 92) begin
                // Broken header: too short, or size byte disagrees.
                if ($urandom_range(1)) begin
                    bad = 8'($urandom_range(MIN_FRAME - 1));
                    b   = beat_of(MODE_GOOD, tx, bad, bad);
                end else begin
                    bad = 8'($urandom);
                    b   = beat_of(MODE_GOOD, tx, len, bad);
                    if (bad == len)
                        b.size_byte = ~bad;
                end
            end else if (r < 95) begin
                b = beat_of(MODE_CLEAR, $urandom, 8'($urandom), 8'($urandom));
            end else begin
                b = beat_of(MODE_GOOD, $urandom, 8'($urandom), 8'($urandom));
            end
            push_beat(b);
        end
    endtask

    initial begin
        frame_beat_t b;
        logic [31:0] tx_a;
        bit          filled;

        cycles       <= 0;
        sent         = 0;
        calm         = 1'b0;
        filled       = 1'b0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        mode         <= MODE_GOOD;
        frame_length <= '0;
        tx_id        <= '0;
        seq_id       <= '0;
        size_byte    <= '0;
        rssi         <= '0;
        lqi          <= '0;
        start_time   <= '0;
        end_time     <= '0;
        read_index   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening.
        tx_a = $urandom;
        // Drop a frame one byte below the minimum length.
        push_beat(beat_of(MODE_GOOD, tx_a, 8'(MIN_FRAME - 1), 8'(MIN_FRAME - 1)));
        // Log a minimum-length frame with extreme payload values.
        b = beat_of(MODE_GOOD, tx_a, 8'(MIN_FRAME), 8'(MIN_FRAME));
        b.seq_id     = 16'h0000;
        b.rssi       = 8'hff;
        b.lqi        = 8'h00;
        b.start_time = 32'h0;
        b.end_time   = 32'hffff_ffff;
        push_beat(b);
        // Drop a frame whose size byte disagrees with its length.
        push_beat(beat_of(MODE_GOOD, tx_a, 8'(MIN_FRAME), 8'(MIN_FRAME + 1)));
        // Same id, new size: count the error but keep the entry.
        push_beat(beat_of(MODE_GOOD, tx_a, 8'hff, 8'hff));
        b = beat_of(MODE_CRC, tx_a, 8'h00, 8'h00);
        b.start_time = 32'hffff_ffff;
        b.end_time   = 32'h0;
        push_beat(b);
        push_read(0);
        push_read(1);
        push_read(2);
        push_beat(beat_of(MODE_GOOD, tx_a, 8'h00, 8'h00));
        // New transmitter: bump the change count and restart the log.
        push_beat(beat_of(MODE_GOOD, 32'hffff_ffff, 8'd20, 8'd20));
        push_read(0);
        push_beat(beat_of(MODE_CLEAR, 32'h0, 8'h0, 8'h0));
        // Slot written before the clear, now above the fill level: no hit.
        push_read(2);
        b = beat_of(MODE_GOOD, 32'h0, 8'(MIN_FRAME), 8'(MIN_FRAME));
        b.seq_id = 16'hffff;
        b.rssi   = 8'h00;
        b.lqi    = 8'hff;
        push_beat(b);
        push_beat(beat_of(MODE_GOOD, 32'h0, 8'd200, 8'd200));
        push_read(0);
        push_read(1);
        push_beat(beat_of(MODE_GOOD, 32'h0, 8'hff, 8'h00));

        // Random traffic, with one burst that drives the log into overflow.
        while (sent < 2000 || !filled) begin
            if (!filled && sent >= 300) begin
                fill_burst();
                filled = 1'b1;
            end else begin
                session();
            end
        end

        // Drain: wait for every result, then idle on to catch stray results.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d beats: %0d log read hits, %0d frames refused on a full log.",
                 n_beats, n_hits, n_full);
        $display("Saw %0d transmitter changes and %0d log clears.", n_changes, n_clears);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
